### src/lca_pkg.sv
package lca_pkg;

   localparam int LINE_BYTES  = 256;
   localparam int CNT_W       = $clog2(LINE_BYTES);
   localparam int WORD_W      = CNT_W - 3;
   localparam int MEM_ROWS    = 2 * LINE_BYTES / 8;
   localparam int ROW_W       = $clog2(MEM_ROWS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   localparam logic [2:0] OP_BYTE      = 3'd0;
   localparam logic [2:0] OP_LINE_ERR  = 3'd1;
   localparam logic [2:0] OP_FETCH     = 3'd2;
   localparam logic [2:0] OP_TAKE_OVF  = 3'd3;
   localparam logic [2:0] OP_TAKE_DROP = 3'd4;
   localparam logic [2:0] OP_TAKE_ERR  = 3'd5;

   typedef enum logic [2:0] {
      CMD_BYTE,
      CMD_LINE_ERR,
      CMD_FETCH,
      CMD_TAKE_OVF,
      CMD_TAKE_DROP,
      CMD_TAKE_ERR,
      CMD_NOP
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_NO_CMD,
      ST_TOO_SMALL,
      ST_ZERO_CAP
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_STREAM
   } back_state_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   rx_byte;
      logic         eol;
      logic         rearm_failed;
      logic [15:0]  capacity;
      logic         cap_zero;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] data_word;
      logic [3:0]  valid_bytes;
      logic [7:0]  command_length;
      logic        taken_flag;
      logic        ready_flag;
      logic        overflow_flag;
      logic        dropped_flag;
      logic        error_flag;
      logic        last;
   } rsp_type;

endpackage

### src/lca_front.sv
module lca_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [2:0]      opcode,
   input  logic [7:0]      rx_byte,
   input  logic            rearm_failed,
   input  logic [15:0]     capacity,
   output logic            head_valid,
   output lca_pkg::cmd_type head,
   input  logic            head_pop
);
   import lca_pkg::*;

   cmd_type               q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;
   cmd_type               cls;
   logic                  push;
   logic                  pop;

   // classify the incoming item
   always_comb begin
      cls.rx_byte      = rx_byte;
      cls.eol          = (rx_byte == CH_CR) || (rx_byte == CH_LF);
      cls.rearm_failed = rearm_failed;
      cls.capacity     = capacity;
      cls.cap_zero     = (capacity == 16'd0);
      unique case (opcode)
         OP_BYTE:      cls.kind = CMD_BYTE;
         OP_LINE_ERR:  cls.kind = CMD_LINE_ERR;
         OP_FETCH:     cls.kind = CMD_FETCH;
         OP_TAKE_OVF:  cls.kind = CMD_TAKE_OVF;
         OP_TAKE_DROP: cls.kind = CMD_TAKE_DROP;
         OP_TAKE_ERR:  cls.kind = CMD_TAKE_ERR;
         default:      cls.kind = CMD_NOP;
      endcase
   end

   assign in_ready   = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = q_ff[rd_ptr_ff];
   assign push       = in_valid && in_ready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### src/lca_back.sv
module lca_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  lca_pkg::cmd_type head,
   output logic             head_pop,
   output logic             out_valid,
   input  logic             out_ready,
   output lca_pkg::rsp_type out_rsp
);
   import lca_pkg::*;

   back_state_type     state_ff, state_in;
   logic               fill_sel_ff, fill_sel_in;
   logic               ready_sel_ff, ready_sel_in;
   logic [CNT_W-1:0]   fill_cnt_ff, fill_cnt_in;
   logic [CNT_W-1:0]   ready_cnt_ff, ready_cnt_in;
   logic               waiting_ff, waiting_in;
   logic               discard_ff, discard_in;
   logic               ovf_ff, ovf_in;
   logic               drop_ff, drop_in;
   logic               err_ff, err_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [WORD_W-1:0]  word_idx_ff, word_idx_in;
   logic [WORD_W-1:0]  last_word_ff, last_word_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   logic [63:0]        mem [MEM_ROWS];
   logic [63:0]        rd_data_ff;
   logic               mem_we;
   logic [ROW_W-1:0]   wr_row;
   logic [2:0]         wr_lane;
   logic               rd_en;
   logic [ROW_W-1:0]   rd_row;

   always_comb begin
      logic               out_free;
      logic               is_last;
      logic [CNT_W-1:0]   cnt_m1;
      logic [CNT_W-1:0]   len_m1;
      logic [3:0]         vbytes;
      logic [63:0]        masked;
      logic               taken;

      state_in     = state_ff;
      fill_sel_in  = fill_sel_ff;
      ready_sel_in = ready_sel_ff;
      fill_cnt_in  = fill_cnt_ff;
      ready_cnt_in = ready_cnt_ff;
      waiting_in   = waiting_ff;
      discard_in   = discard_ff;
      ovf_in       = ovf_ff;
      drop_in      = drop_ff;
      err_in       = err_ff;
      len_in       = len_ff;
      word_idx_in  = word_idx_ff;
      last_word_in = last_word_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      head_pop     = 1'b0;
      mem_we       = 1'b0;
      wr_row       = {fill_sel_ff, fill_cnt_ff[CNT_W-1:3]};
      wr_lane      = fill_cnt_ff[2:0];
      rd_en        = 1'b0;
      rd_row       = {ready_sel_ff, word_idx_ff + WORD_W'(1)};
      out_free     = !out_valid_ff || out_ready;
      cnt_m1       = ready_cnt_ff - CNT_W'(1);
      len_m1       = len_ff - CNT_W'(1);
      is_last      = (word_idx_ff == last_word_ff);
      vbytes       = is_last ? ({1'b0, len_m1[2:0]} + 4'd1) : 4'd8;
      taken        = 1'b0;
      for (int i = 0; i < 8; i++) begin
         masked[i*8 +: 8] = (4'(i) < vbytes) ? rd_data_ff[i*8 +: 8] : 8'h00;
      end

      unique case (state_ff)
         BK_IDLE: begin
            if (head_valid && out_free) begin
               out_in.status         = ST_OK;
               out_in.data_word      = '0;
               out_in.valid_bytes    = '0;
               out_in.command_length = '0;
               out_in.last           = 1'b1;
               out_valid_in          = 1'b1;
               head_pop              = 1'b1;
               unique case (head.kind)
                  CMD_BYTE: begin
                     if (discard_ff) begin
                        if (head.eol) begin
                           discard_in  = 1'b0;
                           fill_cnt_in = '0;
                        end
                     end else if (head.eol) begin
                        if (fill_cnt_ff != '0) begin
                           if (!waiting_ff) begin
                              ready_sel_in = fill_sel_ff;
                              ready_cnt_in = fill_cnt_ff;
                              waiting_in   = 1'b1;
                              fill_sel_in  = !fill_sel_ff;
                           end else begin
                              drop_in = 1'b1;
                           end
                           fill_cnt_in = '0;
                        end
                     end else if (fill_cnt_ff != CNT_W'(LINE_BYTES - 1)) begin
                        mem_we      = 1'b1;
                        fill_cnt_in = fill_cnt_ff + CNT_W'(1);
                     end else begin
                        fill_cnt_in = '0;
                        discard_in  = 1'b1;
                        ovf_in      = 1'b1;
                     end
                     if (head.rearm_failed) begin
                        err_in = 1'b1;
                     end
                  end
                  CMD_LINE_ERR: begin
                     fill_cnt_in = '0;
                     discard_in  = 1'b0;
                     err_in      = 1'b1;
                  end
                  CMD_FETCH: begin
                     priority if (head.cap_zero) begin
                        out_in.status = ST_ZERO_CAP;
                     end else if (!waiting_ff) begin
                        out_in.status = ST_NO_CMD;
                     end else if ((16'(ready_cnt_ff) + 16'd1) > head.capacity) begin
                        out_in.status = ST_TOO_SMALL;
                     end else begin
                        // free the waiting line and start streaming it
                        out_valid_in = out_valid_ff && !out_ready;
                        head_pop     = 1'b0;
                        waiting_in   = 1'b0;
                        ready_cnt_in = '0;
                        len_in       = ready_cnt_ff;
                        last_word_in = cnt_m1[CNT_W-1:3];
                        word_idx_in  = '0;
                        rd_en        = 1'b1;
                        rd_row       = {ready_sel_ff, WORD_W'(0)};
                        state_in     = BK_STREAM;
                     end
                  end
                  CMD_TAKE_OVF: begin
                     taken  = ovf_ff;
                     ovf_in = 1'b0;
                  end
                  CMD_TAKE_DROP: begin
                     taken   = drop_ff;
                     drop_in = 1'b0;
                  end
                  CMD_TAKE_ERR: begin
                     taken  = err_ff;
                     err_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
               out_in.taken_flag    = taken;
               out_in.ready_flag    = waiting_in;
               out_in.overflow_flag = ovf_in;
               out_in.dropped_flag  = drop_in;
               out_in.error_flag    = err_in;
            end
         end
         BK_STREAM: begin
            if (out_free) begin
               out_valid_in          = 1'b1;
               out_in.status         = ST_OK;
               out_in.data_word      = masked;
               out_in.valid_bytes    = vbytes;
               out_in.command_length = 8'(len_ff);
               out_in.taken_flag     = 1'b0;
               out_in.ready_flag     = waiting_ff;
               out_in.overflow_flag  = ovf_ff;
               out_in.dropped_flag   = drop_ff;
               out_in.error_flag     = err_ff;
               out_in.last           = is_last;
               if (is_last) begin
                  head_pop = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  word_idx_in = word_idx_ff + WORD_W'(1);
                  rd_en       = 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         fill_sel_ff  <= 1'b0;
         ready_sel_ff <= 1'b0;
         fill_cnt_ff  <= '0;
         ready_cnt_ff <= '0;
         waiting_ff   <= 1'b0;
         discard_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         drop_ff      <= 1'b0;
         err_ff       <= 1'b0;
         word_idx_ff  <= '0;
         last_word_ff <= '0;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_sel_ff  <= fill_sel_in;
         ready_sel_ff <= ready_sel_in;
         fill_cnt_ff  <= fill_cnt_in;
         ready_cnt_ff <= ready_cnt_in;
         waiting_ff   <= waiting_in;
         discard_ff   <= discard_in;
         ovf_ff       <= ovf_in;
         drop_ff      <= drop_in;
         err_ff       <= err_in;
         word_idx_ff  <= word_idx_in;
         last_word_ff <= last_word_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // line store: byte-lane write, registered word read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_row][{wr_lane, 3'b000} +: 8] <= head.rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

endmodule

### src/line_command_assembler_core.sv
// Line command assembler: gathers received bytes into two ping-pong line stores
// and hands complete lines to a consumer on request.
//
// req channel: one operation per item. req_tuser carries the opcode (byte
// received, line error, fetch, take overflow/dropped/error flag). A short
// command queue sits behind req_tready, so items are taken one per cycle
// until it fills.
// rsp channel: every operation gives one item, except a successful fetch,
// which streams ceil(length/8) items of up to eight bytes, tlast on the final
// one. rsp_tuser carries the status of the operation.
//
// Timing: a non-fetch result goes from the queue to the result register; a fetch
// first reads the line store into its read register, then streams one word per
// cycle while rsp_tready is high. Throughput is one item per cycle when not
// stalled, set by the execute unit, which handles one queued operation at a time;
// a fetch holds it to its last word, as the line store gives one 8-byte word per read.
//
// Reset clears all flags, counts and the queue; the line store is not cleared and
// needs no start-up pass. While rsp_tvalid is high and rsp_tready is low, the
// result register holds and the execute unit stalls; the queue takes items until full.
module line_command_assembler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // rx_byte[7:0], rearm_failed[8], capacity[24:9]
   input  logic [2:0]  req_tuser,   // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // data_word[63:0], valid_bytes[67:64],
                                    // command_length[75:68], taken_flag[76],
                                    // ready_flag[77], overflow_flag[78],
                                    // dropped_flag[79], error_flag[80]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast
);
   import lca_pkg::*;

   logic    head_valid;
   cmd_type head;
   logic    head_pop;
   rsp_type rsp;

   lca_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .opcode       (req_tuser),
      .rx_byte      (req_tdata[7:0]),
      .rearm_failed (req_tdata[8]),
      .capacity     (req_tdata[24:9]),
      .head_valid   (head_valid),
      .head         (head),
      .head_pop     (head_pop)
   );

   lca_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rsp    (rsp)
   );

   assign rsp_tdata = {7'd0, rsp.error_flag, rsp.dropped_flag, rsp.overflow_flag,
                       rsp.ready_flag, rsp.taken_flag, rsp.command_length,
                       rsp.valid_bytes, rsp.data_word};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule
